### rtl/core/soundex_encoder_macros.svh
// ----------------------------------------------------------------------------
// soundex_encoder_macros
// Assertion helpers for the soundex encoder.
// ----------------------------------------------------------------------------
// both sample on the rising edge of clock and are off while reset is high
`ifndef SOUNDEX_ENCODER_MACROS_SVH
`define SOUNDEX_ENCODER_MACROS_SVH

// consequent checked in the same cycle
`define SDX_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("sdx assertion failed");

// consequent checked in the cycle after the antecedent
`define SDX_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("sdx assertion failed");

`endif

### rtl/core/sdx_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdx_pkg
// Shared constants, types and the byte classifier of the soundex encoder.
// ----------------------------------------------------------------------------
package sdx_pkg;

   localparam int CODE_CHARS = 4;
   localparam int CNT_W      = $clog2(CODE_CHARS + 1);

   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_ONE  = 8'h31;
   localparam logic [7:0] CHAR_TWO  = 8'h32;
   localparam logic [7:0] CHAR_THREE = 8'h33;
   localparam logic [7:0] CHAR_FOUR = 8'h34;
   localparam logic [7:0] CHAR_FIVE = 8'h35;
   localparam logic [7:0] CHAR_SIX  = 8'h36;

   // kind of a classified word
   localparam logic [1:0] KIND_TERM  = 2'd0;
   localparam logic [1:0] KIND_SKIP  = 2'd1;
   localparam logic [1:0] KIND_DIGIT = 2'd2;
   localparam logic [1:0] KIND_OTHER = 2'd3;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] lowered;
      logic [7:0] digit;
   } item_type;

   function automatic item_type classify(input logic [7:0] sym);
      item_type   it;
      logic [7:0] low;
      low = ((sym >= 8'h41) && (sym <= 8'h5a)) ? (sym + 8'd32) : sym;
      it.lowered = low;
      it.digit   = CHAR_ZERO;
      it.kind    = KIND_OTHER;
      if (sym == 8'h00) begin
         it.kind = KIND_TERM;
      end else begin
         unique case (low)
            "a", "e", "h", "i", "o", "u", "w", "y": it.kind = KIND_SKIP;
            "b", "f", "p", "v": begin
               it.kind  = KIND_DIGIT;
               it.digit = CHAR_ONE;
            end
            "c", "g", "j", "k", "q", "s", "x", "z": begin
               it.kind  = KIND_DIGIT;
               it.digit = CHAR_TWO;
            end
            "d", "t": begin
               it.kind  = KIND_DIGIT;
               it.digit = CHAR_THREE;
            end
            "l": begin
               it.kind  = KIND_DIGIT;
               it.digit = CHAR_FOUR;
            end
            "m", "n": begin
               it.kind  = KIND_DIGIT;
               it.digit = CHAR_FIVE;
            end
            "r": begin
               it.kind  = KIND_DIGIT;
               it.digit = CHAR_SIX;
            end
            default: it.kind = KIND_OTHER;
         endcase
      end
      return it;
   endfunction

endpackage

### rtl/core/sdx_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdx_if
// Valid/ready channels of the soundex encoder: input bytes and result codes.
// ----------------------------------------------------------------------------
interface sdx_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] symbol;

   modport source (output valid, output symbol, input ready);
   modport sink   (input valid, input symbol, output ready);
endinterface

interface sdx_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] code_0;
   logic [7:0] code_1;
   logic [7:0] code_2;
   logic [7:0] code_3;
   logic [2:0] code_length;

   modport source (output valid, output code_0, output code_1, output code_2,
                   output code_3, output code_length, input ready);
   modport sink   (input valid, input code_0, input code_1, input code_2,
                   input code_3, input code_length, output ready);
endinterface

### rtl/core/sdx_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdx_front
// Accepts input words, classifies each byte and registers the result.
// ----------------------------------------------------------------------------
module sdx_front (
   input  logic              clock,
   input  logic              reset,
   sdx_req_if.sink           req_if,
   output logic              push_valid,
   input  logic              push_ready,
   output sdx_pkg::item_type push_item
);

   logic              valid_ff, valid_in;
   sdx_pkg::item_type item_ff, item_in;
   logic              take;

   assign req_if.ready = !valid_ff || push_ready;
   assign take         = req_if.valid && req_if.ready;

   always_comb begin
      item_in  = item_ff;
      valid_in = valid_ff;
      if (take) begin
         item_in  = sdx_pkg::classify(req_if.symbol);
         valid_in = 1'b1;
      end else if (push_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign push_valid = valid_ff;
   assign push_item  = item_ff;

endmodule

### rtl/core/sdx_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdx_queue
// Two-entry queue of classified words between front and back.
// ----------------------------------------------------------------------------
module sdx_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  sdx_pkg::item_type push_item,
   output logic              pop_valid,
   input  logic              pop_ready,
   output sdx_pkg::item_type pop_item
);

   sdx_pkg::item_type mem_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        count_ff, count_in;
   logic              push, pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_item   = mem_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

### rtl/core/sdx_back.sv
`timescale 1ns / 1ps
`include "soundex_encoder_macros.svh"
// ----------------------------------------------------------------------------
// sdx_back
// Builds the code from classified words and holds the finished result.
// ----------------------------------------------------------------------------
module sdx_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              pop_valid,
   output logic              pop_ready,
   input  sdx_pkg::item_type pop_item,
   sdx_rsp_if.source         rsp_if
);

   logic [7:0]                store_ff [sdx_pkg::CODE_CHARS];
   logic [7:0]                store_in [sdx_pkg::CODE_CHARS];
   logic [7:0]                pad_store [sdx_pkg::CODE_CHARS];
   logic [sdx_pkg::CNT_W-1:0] count_ff, count_in, pad_count;
   logic                      frozen_ff, frozen_in;
   logic                      out_valid_ff, out_valid_in;
   logic [7:0]                code_ff [4];
   logic [7:0]                code_in [4];
   logic [2:0]                len_ff, len_in;
   logic [7:0]                last_char;
   logic                      is_term, out_free, pop, pop_term, pad;

   assign is_term   = (pop_item.kind == sdx_pkg::KIND_TERM);
   assign out_free  = !out_valid_ff || rsp_if.ready;
   assign pop_ready = !is_term || out_free;
   assign pop       = pop_valid && pop_ready;
   assign pop_term  = pop && is_term;
   assign pad       = (count_ff != '0) && !frozen_ff;

   always_comb begin
      last_char = '0;
      for (int k = 0; k < sdx_pkg::CODE_CHARS; k++) begin
         if (k + 1 == int'(count_ff)) begin
            last_char = store_ff[k];
         end
      end
      for (int k = 0; k < sdx_pkg::CODE_CHARS; k++) begin
         pad_store[k] = (pad && (k >= int'(count_ff))) ? sdx_pkg::CHAR_ZERO : store_ff[k];
      end
      pad_count = pad ? sdx_pkg::CNT_W'(sdx_pkg::CODE_CHARS) : count_ff;
   end

   always_comb begin
      store_in  = store_ff;
      count_in  = count_ff;
      frozen_in = frozen_ff;
      if (pop) begin
         priority if (is_term) begin
            for (int k = 0; k < sdx_pkg::CODE_CHARS; k++) begin
               store_in[k] = '0;
            end
            count_in  = '0;
            frozen_in = 1'b0;
         end else if (count_ff == '0) begin
            store_in[0] = pop_item.lowered;
            count_in    = sdx_pkg::CNT_W'(1);
         end else if (frozen_ff) begin
            frozen_in = 1'b1;
         end else if (pop_item.kind == sdx_pkg::KIND_OTHER) begin
            frozen_in = 1'b1;
         end else if (pop_item.kind == sdx_pkg::KIND_DIGIT) begin
            // equal digits merge, also across skipped letters
            if ((int'(count_ff) < sdx_pkg::CODE_CHARS) && (last_char != pop_item.digit)) begin
               for (int k = 0; k < sdx_pkg::CODE_CHARS; k++) begin
                  if (k == int'(count_ff)) begin
                     store_in[k] = pop_item.digit;
                  end
               end
               count_in = count_ff + sdx_pkg::CNT_W'(1);
            end
         end else begin
            count_in = count_ff;
         end
      end
   end

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         code_in[k] = code_ff[k];
         if (pop_term) begin
            code_in[k] = (k < sdx_pkg::CODE_CHARS) ? pad_store[k] : 8'h00;
         end
      end
      len_in = len_ff;
      if (pop_term) begin
         len_in = (int'(pad_count) > 7) ? 3'd7 : 3'(pad_count);
      end
      out_valid_in = pop_term ? 1'b1 : (rsp_if.ready ? 1'b0 : out_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < sdx_pkg::CODE_CHARS; k++) begin
            store_ff[k] <= '0;
         end
         count_ff     <= '0;
         frozen_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         store_ff     <= store_in;
         count_ff     <= count_in;
         frozen_ff    <= frozen_in;
         out_valid_ff <= out_valid_in;
      end
      code_ff <= code_in;
      len_ff  <= len_in;
   end

   assign rsp_if.valid       = out_valid_ff;
   assign rsp_if.code_0      = code_ff[0];
   assign rsp_if.code_1      = code_ff[1];
   assign rsp_if.code_2      = code_ff[2];
   assign rsp_if.code_3      = code_ff[3];
   assign rsp_if.code_length = len_ff;

   `SDX_ASSERT_SAME(a_count_bound, 1'b1, int'(count_ff) <= sdx_pkg::CODE_CHARS)
   `SDX_ASSERT_SAME(a_frozen_needs_first, frozen_ff, count_ff != '0)
   `SDX_ASSERT_NEXT(a_term_clears, pop_term, (count_ff == '0) && !frozen_ff)
   `SDX_ASSERT_NEXT(a_term_loads_out, pop_term, out_valid_ff)

endmodule

### rtl/core/soundex_encoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// soundex_encoder
// Streaming phonetic encoder: one byte per word, a zero byte ends the string.
// ----------------------------------------------------------------------------
// a result is loaded into the back's output register after its terminating byte passes the front register and the queue
// throughput: one byte per cycle unless a held result stalls a terminator, set by the code update in the back
// a held result stalls only terminators at the back; bytes behind one then wait in the queue and the front
// reset: synchronous, clears the code, the queue and the output valid flag
module soundex_encoder (
   input  logic       clock,
   input  logic       reset,
   sdx_req_if.sink    req_if,
   sdx_rsp_if.source  rsp_if
);

   logic              push_valid, push_ready;
   sdx_pkg::item_type push_item;
   logic              pop_valid, pop_ready;
   sdx_pkg::item_type pop_item;

   sdx_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item)
   );

   sdx_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   sdx_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_item  (pop_item),
      .rsp_if    (rsp_if)
   );

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the soundex encoder. Bytes go in on the request
// channel, and a tracker class works out the expected code of each string.
// Every code that comes back is checked field by field, through phases of
// neither, idling on the sender, stalling on the receiver, and both.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int TOTAL_BYTES = 950;

   typedef struct packed {
      logic [7:0] code_0;
      logic [7:0] code_1;
      logic [7:0] code_2;
      logic [7:0] code_3;
      logic [2:0] code_length;
   } code_word_type;

   class phonetic_code_tracker;
      code_word_type pending_codes[$];
      logic [7:0]    code_chars[sdx_pkg::CODE_CHARS];
      int            filled;
      bit            frozen;
      int            errors;

      function new();
         clear_code();
         errors = 0;
      endfunction

      function void clear_code();
         foreach (code_chars[k]) code_chars[k] = 8'h00;
         filled = 0;
         frozen = 0;
      endfunction

      static function logic [7:0] lower_case(logic [7:0] sym);
         return (sym >= "A" && sym <= "Z") ? sym + 8'd32 : sym;
      endfunction

      // kind of a letter after the first byte, and its digit class
      static function logic [1:0] letter_class(logic [7:0] sym, output logic [7:0] dig);
         dig = sdx_pkg::CHAR_ZERO;
         case (lower_case(sym))
            "a", "e", "h", "i", "o", "u", "w", "y": return sdx_pkg::KIND_SKIP;
            "b", "f", "p", "v": dig = sdx_pkg::CHAR_ONE;
            "c", "g", "j", "k", "q", "s", "x", "z": dig = sdx_pkg::CHAR_TWO;
            "d", "t": dig = sdx_pkg::CHAR_THREE;
            "l": dig = sdx_pkg::CHAR_FOUR;
            "m", "n": dig = sdx_pkg::CHAR_FIVE;
            "r": dig = sdx_pkg::CHAR_SIX;
            default: return sdx_pkg::KIND_OTHER;
         endcase
         return sdx_pkg::KIND_DIGIT;
      endfunction

      // one accepted input word; a terminator queues the finished code
      function void note_byte(logic [7:0] sym);
         code_word_type res;
         logic [1:0]    kind;
         logic [7:0]    dig;
         if (sym == 8'h00) begin
            if (filled > 0 && !frozen) begin
               while (filled < sdx_pkg::CODE_CHARS) begin
                  code_chars[filled] = sdx_pkg::CHAR_ZERO;
                  filled++;
               end
            end
            res.code_0      = code_chars[0];
            res.code_1      = code_chars[1];
            res.code_2      = code_chars[2];
            res.code_3      = code_chars[3];
            res.code_length = (filled > 7) ? 3'd7 : filled[2:0];
            pending_codes.push_back(res);
            clear_code();
         end else if (filled == 0) begin
            code_chars[0] = lower_case(sym);
            filled = 1;
         end else if (!frozen) begin
            kind = letter_class(sym, dig);
            if (kind == sdx_pkg::KIND_OTHER) begin
               frozen = 1;
            end else if (kind == sdx_pkg::KIND_DIGIT) begin
               // vowels leave the last character alone, so equal digits merge across them
               if (filled < sdx_pkg::CODE_CHARS && code_chars[filled-1] != dig) begin
                  code_chars[filled] = dig;
                  filled++;
               end
            end
         end
      endfunction

      function void compare_field(string name, logic [7:0] want, logic [7:0] got);
         if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            errors++;
         end
      endfunction

      function void check_code(code_word_type got);
         code_word_type want;
         if (pending_codes.size() == 0) begin
            $display("%0t: unexpected code word, actual %h", $time, got);
            errors++;
            return;
         end
         want = pending_codes.pop_front();
         compare_field("code_0", want.code_0, got.code_0);
         compare_field("code_1", want.code_1, got.code_1);
         compare_field("code_2", want.code_2, got.code_2);
         compare_field("code_3", want.code_3, got.code_3);
         compare_field("code_length", {5'd0, want.code_length}, {5'd0, got.code_length});
      endfunction
   endclass

   logic clock;
   logic reset;

   sdx_req_if req_bus();
   sdx_rsp_if rsp_bus();

   soundex_encoder dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus)
   );

   phonetic_code_tracker tracker = new();
   int bytes_sent     = 0;
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("tb_top failed");
      $finish;
   end

   // receiver: ready changes on the falling edge
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_bus.ready = ($urandom_range(99) >= recv_stall_pct);
      end
   end

   initial begin
      code_word_type got;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            got.code_0      = rsp_bus.code_0;
            got.code_1      = rsp_bus.code_1;
            got.code_2      = rsp_bus.code_2;
            got.code_3      = rsp_bus.code_3;
            got.code_length = rsp_bus.code_length;
            tracker.check_code(got);
         end
      end
   end

   task automatic send_byte(logic [7:0] sym);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid = 1'b0;
         @(negedge clock);
      end
      req_bus.valid  = 1'b1;
      req_bus.symbol = sym;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      tracker.note_byte(sym);
      bytes_sent++;
   endtask

   task automatic send_text(string s);
      for (int i = 0; i < s.len(); i++) send_byte(s[i]);
      send_byte(8'h00);
   endtask

   // mostly letters of either case, some stray non-letters and high bytes
   task automatic send_random_name();
      int         n;
      int         pick;
      logic [7:0] sym;
      n = ($urandom_range(9) == 0) ? 0 : $urandom_range(12, 1);
      for (int i = 0; i < n; i++) begin
         pick = $urandom_range(99);
         if (pick < 88) begin
            sym = 8'h61 + 8'($urandom_range(25));
            if ($urandom_range(1)) sym = sym - 8'd32;
         end else if (pick < 94) begin
            sym = 8'($urandom_range(255, 128));
         end else begin
            do sym = 8'($urandom_range(127, 1));
            while ((sym >= "a" && sym <= "z") || (sym >= "A" && sym <= "Z"));
         end
         send_byte(sym);
      end
      send_byte(8'h00);
   endtask

   initial begin
      reset          = 1'b1;
      req_bus.valid  = 1'b0;
      req_bus.symbol = 8'h00;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed strings
      send_byte(8'h00);
      send_text("Kbab");
      send_text("ZQBDL-M");
      send_byte(8'hff);
      send_text("b");
      send_text("1b");
      send_byte("a");
      send_byte(8'h80);
      send_text("d");

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
            default: begin send_idle_pct = 30; recv_stall_pct = 30; end
         endcase
         while (bytes_sent < 24 + (phase + 1) * (TOTAL_BYTES - 24) / 4) send_random_name();
      end

      @(negedge clock);
      req_bus.valid = 1'b0;
      while (tracker.pending_codes.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (tracker.errors == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

endmodule
